/* hdl/uer_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package uer_pkg;

    typedef enum logic [1:0] {
        PH_TRIG = 2'd0,
        PH_ECHO = 2'd1,
        PH_HOLD = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        REG_PULSE_COUNT = 2'd0,
        REG_PULSE_HALF  = 2'd1,
        REG_HOLD_TICKS  = 2'd2,
        REG_CM_SCALE    = 2'd3
    } t_reg_idx;

    localparam logic [4:0]  PULSE_COUNT_RST = 5'd8;
    localparam logic [7:0]  PULSE_HALF_RST  = 8'd9;
    localparam logic [19:0] HOLD_TICKS_RST  = 20'd368640;
    localparam logic [15:0] CM_SCALE_RST    = 16'd1209;
    localparam logic [9:0]  CM_MAX          = 10'd999;

    // intermediate beat: one tick's result before display decode
    typedef struct packed {
        logic       trig;
        logic       done;
        logic       timed_out;
        logic [9:0] cm;
    } t_mid;

    typedef struct packed {
        logic [13:0] tenths;
        logic [7:0]  seg_h;
        logic [7:0]  seg_t;
        logic [7:0]  seg_u;
        logic [7:0]  seg_f;
    } t_disp;

    // active-low seven-segment pattern, bit 7 is the decimal point
    function automatic logic [7:0] seg_of(input logic [3:0] d);
        logic [7:0] p;
        case (d)
            4'd0:    p = 8'hC0;
            4'd1:    p = 8'hF9;
            4'd2:    p = 8'hA4;
            4'd3:    p = 8'hB0;
            4'd4:    p = 8'h99;
            4'd5:    p = 8'h92;
            4'd6:    p = 8'h82;
            4'd7:    p = 8'hF8;
            4'd8:    p = 8'h80;
            4'd9:    p = 8'h90;
            default: p = 8'hFF;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

/* hdl/uer_disp.sv */
`timescale 1ns / 1ps
`default_nettype none
module uer_disp (
    input  wire logic [9:0]     i_cm,
    output uer_pkg::t_disp      o_disp
);

    logic [15:0] hund_prod;
    logic [3:0]  hund;
    logic [6:0]  rem_h;
    logic [14:0] tens_prod;
    logic [3:0]  tens;
    logic [3:0]  units;

    // divide by 100 and by 10 with reciprocal multiplies, exact over 0..999
    always_comb begin
        hund_prod = 16'(i_cm) * 16'd41;
        hund      = hund_prod[15:12];
        rem_h     = 7'(i_cm - 10'(hund) * 10'd100);
        tens_prod = 15'(rem_h) * 15'd205;
        tens      = tens_prod[14:11];
        units     = 4'(rem_h - 7'(tens) * 7'd10);

        o_disp.tenths = {1'b0, i_cm, 3'b000} + {3'b000, i_cm, 1'b0};
        o_disp.seg_h  = uer_pkg::seg_of(hund);
        o_disp.seg_t  = uer_pkg::seg_of(tens);
        o_disp.seg_u  = uer_pkg::seg_of(units) & 8'h7F;
        o_disp.seg_f  = uer_pkg::seg_of(4'd0);
    end

endmodule
`default_nettype wire

/* hdl/ultrasonic_echo_ranger.sv */
`timescale 1ns / 1ps
`default_nettype none
// Ultrasonic time-of-flight ranger. Each input beat is one measurement tick
// carrying the sampled echo level, and each tick yields exactly one result beat
// (trigger drive, done pulse, timeout flag, distance in tenths of a cm and four
// active-low digit patterns). One beat is taken every cycle unless o_in_stall is
// high. The sequencer and the tick-count by scale multiply update the state
// at the accepting edge, the digit split and segment decode fill the output
// register as the beat advances. COUNT_BITS sets the echo counter width and
// thus the timeout limit of 2**COUNT_BITS ticks.
// Registers sit at byte addresses 0, 4, 8, 12: pulse count, pulse half width,
// hold ticks, centimeters per tick in Q0.16.
module ultrasonic_echo_ranger #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_echo_level,

    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_trig_level,
    output logic             o_done_res,
    output logic             o_timed_out,
    output logic      [13:0] o_distance_tenths,
    output logic      [7:0]  o_seg_hundreds,
    output logic      [7:0]  o_seg_tens,
    output logic      [7:0]  o_seg_units,
    output logic      [7:0]  o_seg_tenths
);

    localparam int PW = COUNT_BITS + 16;
    localparam int SW = COUNT_BITS + 10;

    logic [4:0]  r_pulse_count;
    logic [7:0]  r_pulse_half;
    logic [19:0] r_hold_ticks;
    logic [15:0] r_cm_scale;

    uer_pkg::t_phase r_phase, n_phase;
    logic [19:0]           r_tick, n_tick;
    logic [4:0]            r_pulses, n_pulses;
    logic [COUNT_BITS-1:0] r_echo_ticks, n_echo_ticks;
    logic                  r_echo_seen, n_echo_seen;
    logic [9:0]            r_dist, n_dist;
    logic                  r_ovf, n_ovf;
    logic                  n_trig, n_done;

    logic            r_mid_valid;
    uer_pkg::t_mid   r_mid;
    logic            r_out_valid;
    logic            r_out_trig, r_out_done, r_out_tmo;
    uer_pkg::t_disp  r_out_disp;
    uer_pkg::t_disp  disp;

    logic                cfg_wr;
    uer_pkg::t_reg_idx   cfg_idx;
    logic                in_acc;
    logic                mid_adv;

    logic [7:0]          half_eff;
    logic [19:0]         hold_eff;
    logic [20:0]         tick_inc;
    logic [COUNT_BITS:0] echo_inc;
    logic [PW-1:0]       prod;
    logic [SW-1:0]       cm_wide;
    logic [9:0]          cm_sat;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = uer_pkg::t_reg_idx'(paddr[3:2]);

    always_comb begin
        unique case (cfg_idx)
            uer_pkg::REG_PULSE_COUNT: prdata = {27'd0, r_pulse_count};
            uer_pkg::REG_PULSE_HALF:  prdata = {24'd0, r_pulse_half};
            uer_pkg::REG_HOLD_TICKS:  prdata = {12'd0, r_hold_ticks};
            uer_pkg::REG_CM_SCALE:    prdata = {16'd0, r_cm_scale};
            default:                  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_count <= uer_pkg::PULSE_COUNT_RST;
            r_pulse_half  <= uer_pkg::PULSE_HALF_RST;
            r_hold_ticks  <= uer_pkg::HOLD_TICKS_RST;
            r_cm_scale    <= uer_pkg::CM_SCALE_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                uer_pkg::REG_PULSE_COUNT: r_pulse_count <= pwdata[4:0];
                uer_pkg::REG_PULSE_HALF:  r_pulse_half  <= pwdata[7:0];
                uer_pkg::REG_HOLD_TICKS:  r_hold_ticks  <= pwdata[19:0];
                uer_pkg::REG_CM_SCALE:    r_cm_scale    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign mid_adv    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_mid_valid && !mid_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    // ---------------- sequencer ----------------
    always_comb begin
        half_eff = (r_pulse_half == 8'd0) ? 8'd1 : r_pulse_half;
        hold_eff = (r_hold_ticks == 20'd0) ? 20'd1 : r_hold_ticks;
        tick_inc = {1'b0, r_tick} + 21'd1;
        echo_inc = {1'b0, r_echo_ticks} + (COUNT_BITS+1)'(1);
        prod     = PW'(r_echo_ticks) * PW'(r_cm_scale);
        cm_wide  = SW'(prod[PW-1:16]);
        cm_sat   = (cm_wide > SW'(uer_pkg::CM_MAX)) ? uer_pkg::CM_MAX : cm_wide[9:0];

        n_phase      = r_phase;
        n_tick       = r_tick;
        n_pulses     = r_pulses;
        n_echo_ticks = r_echo_ticks;
        n_echo_seen  = r_echo_seen;
        n_dist       = r_dist;
        n_ovf        = r_ovf;
        n_trig       = 1'b0;
        n_done       = 1'b0;

        unique case (r_phase)
            uer_pkg::PH_TRIG: begin
                n_trig = (r_tick < {12'd0, half_eff});
                if (tick_inc >= {12'd0, half_eff, 1'b0}) begin
                    n_tick = 20'd0;
                    if (({1'b0, r_pulses} + 6'd1) >= {1'b0, r_pulse_count}) begin
                        n_pulses     = 5'd0;
                        n_phase      = uer_pkg::PH_ECHO;
                        n_echo_ticks = '0;
                        n_echo_seen  = 1'b0;
                    end else begin
                        n_pulses = r_pulses + 5'd1;
                    end
                end else begin
                    n_tick = tick_inc[19:0];
                end
            end
            uer_pkg::PH_ECHO: begin
                if (!r_echo_seen && i_echo_level) begin
                    n_echo_seen  = 1'b1;
                    n_echo_ticks = COUNT_BITS'(1);
                end else if (!r_echo_seen || i_echo_level) begin
                    if (echo_inc[COUNT_BITS]) begin
                        n_done = 1'b1;
                        n_dist = uer_pkg::CM_MAX;
                        n_ovf  = 1'b1;
                    end else begin
                        n_echo_ticks = echo_inc[COUNT_BITS-1:0];
                    end
                end else begin
                    n_done = 1'b1;
                    n_dist = cm_sat;
                    n_ovf  = 1'b0;
                end
                if (n_done) begin
                    n_phase      = uer_pkg::PH_HOLD;
                    n_tick       = 20'd0;
                    n_echo_ticks = '0;
                    n_echo_seen  = 1'b0;
                end
            end
            uer_pkg::PH_HOLD: begin
                if (tick_inc >= {1'b0, hold_eff}) begin
                    n_phase      = uer_pkg::PH_TRIG;
                    n_tick       = 20'd0;
                    n_pulses     = 5'd0;
                    n_echo_ticks = '0;
                    n_echo_seen  = 1'b0;
                end else begin
                    n_tick = tick_inc[19:0];
                end
            end
            default: begin
                n_phase = uer_pkg::PH_TRIG;
                n_tick  = 20'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= uer_pkg::PH_TRIG;
            r_tick       <= 20'd0;
            r_pulses     <= 5'd0;
            r_echo_ticks <= '0;
            r_echo_seen  <= 1'b0;
            r_dist       <= 10'd0;
            r_ovf        <= 1'b0;
        end else if (in_acc) begin
            r_phase      <= n_phase;
            r_tick       <= n_tick;
            r_pulses     <= n_pulses;
            r_echo_ticks <= n_echo_ticks;
            r_echo_seen  <= n_echo_seen;
            r_dist       <= n_dist;
            r_ovf        <= n_ovf;
        end
    end

    // ---------------- intermediate and output registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_mid_valid <= 1'b1;
            end else if (mid_adv) begin
                r_mid_valid <= 1'b0;
            end
            if (mid_adv) begin
                r_out_valid <= r_mid_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mid.trig      <= n_trig;
            r_mid.done      <= n_done;
            r_mid.timed_out <= n_ovf;
            r_mid.cm        <= n_dist;
        end
        if (mid_adv && r_mid_valid) begin
            r_out_trig <= r_mid.trig;
            r_out_done <= r_mid.done;
            r_out_tmo  <= r_mid.timed_out;
            r_out_disp <= disp;
        end
    end

    uer_disp u_disp (
        .i_cm   (r_mid.cm),
        .o_disp (disp)
    );

    assign o_out_valid       = r_out_valid;
    assign o_trig_level      = r_out_trig;
    assign o_done_res        = r_out_done;
    assign o_timed_out       = r_out_tmo;
    assign o_distance_tenths = r_out_disp.tenths;
    assign o_seg_hundreds    = r_out_disp.seg_h;
    assign o_seg_tens        = r_out_disp.seg_t;
    assign o_seg_units       = r_out_disp.seg_u;
    assign o_seg_tenths      = r_out_disp.seg_f;

`ifndef NO_ASSERTIONS
    a_done_enters_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && n_done |=> r_phase == uer_pkg::PH_HOLD && r_mid.done)
        else $error("finished measurement did not enter hold");

    a_trig_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && n_trig |-> r_phase == uer_pkg::PH_TRIG)
        else $error("trigger driven outside burst");

    a_timeout_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mid_valid && r_mid.timed_out |-> r_mid.cm == uer_pkg::CM_MAX)
        else $error("timeout without saturated distance");

    a_cm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dist <= uer_pkg::CM_MAX)
        else $error("distance above saturation limit");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mid_valid && !mid_adv |=> r_mid_valid && $stable(r_mid))
        else $error("stalled intermediate beat lost");
`endif

endmodule
`default_nettype wire
